// ===== src/box_quad_overlap_sat_test_defines.svh =====
// assertion macros shared by the box versus near quad overlap checker
`ifndef BOX_QUAD_OVERLAP_SAT_TEST_DEFINES_SVH
`define BOX_QUAD_OVERLAP_SAT_TEST_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define BQO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define BQO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/bqo_pkg.sv =====
// shared constants, codes and types of the box versus near quad overlap test
package bqo_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 32;
  localparam int unsigned FIELD_W         = 32;
  localparam int unsigned XY_W            = 2 * FIELD_W;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned NUM_AXES        = 2;
  localparam int unsigned NUM_TERMS       = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CORNER_A   = 3'd0,
    CFG_CORNER_B   = 3'd1,
    CFG_CORNER_C   = 3'd2,
    CFG_CORNER_D   = 3'd3,
    CFG_NEAR_TOP_Z = 3'd4
  } bqo_cfg_idx_e;

  typedef struct packed {
    logic depth_sep;
    logic bounds_sep;
  } bqo_flags_t;

endpackage

// ===== src/bqo_intf.sv =====
// request channels: box in, overlap flag out, register writes in
interface bqo_box_if;
  import bqo_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] box_low_x;
  logic signed [FIELD_W-1:0] box_low_y;
  logic signed [FIELD_W-1:0] box_low_z;
  logic signed [FIELD_W-1:0] box_high_x;
  logic signed [FIELD_W-1:0] box_high_y;
  modport source (output valid, box_low_x, box_low_y, box_low_z, box_high_x, box_high_y,
                  input ready);
  modport sink (input valid, box_low_x, box_low_y, box_low_z, box_high_x, box_high_y,
                output ready);
endinterface

interface bqo_flag_if;
  logic valid;
  logic ready;
  logic camera_shadowed;
  modport source (output valid, camera_shadowed, input ready);
  modport sink (input valid, camera_shadowed, output ready);
endinterface

interface bqo_cfg_if;
  import bqo_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [XY_W-1:0]      data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/box_quad_overlap_sat_test.sv =====
// top level of the box versus camera near quad separating axis test
// Each accepted box request passes through the product, range and result
// registers before its camera_shadowed flag shows on the output, and a new
// box is taken every clock while the pipeline is not full.
// The path is an input register, a stage of sixteen parallel 33 by 32 bit
// products, a stage of sums and range extremes, and the result register;
// each stage holds its own valid bit, so bubbles close up while the result
// waits and box_i.ready falls only when all four stages are full. Register
// writes are always accepted and apply to boxes accepted after them; the user
// ensures they are made while no box is in flight, which is not enforced.
// COORD_WIDTH below 32 takes the low bits of each coordinate, sign extended.
module box_quad_overlap_sat_test #(
  parameter int unsigned COORD_WIDTH = bqo_pkg::COORD_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bqo_box_if.sink    box_i,
  bqo_flag_if.source flag_o,
  bqo_cfg_if.sink    cfg_i
);
  import bqo_pkg::*;

  localparam int unsigned CW = (COORD_WIDTH < FIELD_W) ? COORD_WIDTH : FIELD_W;
  localparam int unsigned PW = 2 * CW + 1;
  localparam int unsigned DW = PW + 1;

  // register file
  logic [XY_W-1:0]    corner_a_q, corner_b_q, corner_c_q, corner_d_q;
  logic [FIELD_W-1:0] near_top_z_q;

  // input register
  logic                      v0_q, v0_d;
  logic signed [FIELD_W-1:0] low_x_q, low_y_q, low_z_q, high_x_q, high_y_q;

  // product register
  logic                 v1_q, v1_d;
  bqo_flags_t           flags1_d, flags1_q;
  logic signed [PW-1:0] quad_prod_d [NUM_AXES][NUM_TERMS];
  logic signed [PW-1:0] quad_prod_q [NUM_AXES][NUM_TERMS];
  logic signed [PW-1:0] box_prod_d  [NUM_AXES][NUM_TERMS];
  logic signed [PW-1:0] box_prod_q  [NUM_AXES][NUM_TERMS];

  // range register
  logic                 v2_q, v2_d;
  bqo_flags_t           flags2_q;
  logic signed [DW-1:0] quad_lo_d  [NUM_AXES];
  logic signed [DW-1:0] quad_lo_q  [NUM_AXES];
  logic signed [DW-1:0] quad_hi_d  [NUM_AXES];
  logic signed [DW-1:0] quad_hi_q  [NUM_AXES];
  logic signed [DW-1:0] proj_min_d [NUM_AXES];
  logic signed [DW-1:0] proj_min_q [NUM_AXES];
  logic signed [DW-1:0] proj_max_d [NUM_AXES];
  logic signed [DW-1:0] proj_max_q [NUM_AXES];

  // result register
  logic v3_q, v3_d;
  logic shadowed_q, shadowed_d;

  logic rdy0, rdy1, rdy2, rdy3;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corner_a_q   <= '0;
      corner_b_q   <= '0;
      corner_c_q   <= '0;
      corner_d_q   <= '0;
      near_top_z_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_CORNER_A:   corner_a_q   <= cfg_i.data;
        CFG_CORNER_B:   corner_b_q   <= cfg_i.data;
        CFG_CORNER_C:   corner_c_q   <= cfg_i.data;
        CFG_CORNER_D:   corner_d_q   <= cfg_i.data;
        CFG_NEAR_TOP_Z: near_top_z_q <= cfg_i.data[FIELD_W-1:0];
        default: ;
      endcase
    end
  end

  // per-stage flow control
  assign rdy3 = !v3_q || flag_o.ready;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign rdy0 = !v0_q || rdy1;

  assign box_i.ready = rdy0;

  assign v0_d = rdy0 ? box_i.valid : v0_q;
  assign v1_d = rdy1 ? v0_q : v1_q;
  assign v2_d = rdy2 ? v1_q : v2_q;
  assign v3_d = rdy3 ? v2_q : v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v0_q <= v0_d;
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy0 && box_i.valid) begin
      low_x_q  <= box_i.box_low_x;
      low_y_q  <= box_i.box_low_y;
      low_z_q  <= box_i.box_low_z;
      high_x_q <= box_i.box_high_x;
      high_y_q <= box_i.box_high_y;
    end
  end

  bqo_mul_stage #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_mul (
    .corner_a_i   (corner_a_q),
    .corner_b_i   (corner_b_q),
    .corner_c_i   (corner_c_q),
    .corner_d_i   (corner_d_q),
    .near_top_z_i (near_top_z_q),
    .box_low_x_i  (low_x_q),
    .box_low_y_i  (low_y_q),
    .box_low_z_i  (low_z_q),
    .box_high_x_i (high_x_q),
    .box_high_y_i (high_y_q),
    .flags_o      (flags1_d),
    .quad_prod_o  (quad_prod_d),
    .box_prod_o   (box_prod_d)
  );

  always_ff @(posedge clk_i) begin
    if (rdy1 && v0_q) begin
      flags1_q    <= flags1_d;
      quad_prod_q <= quad_prod_d;
      box_prod_q  <= box_prod_d;
    end
  end

  bqo_sum_stage #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_sum (
    .quad_prod_i (quad_prod_q),
    .box_prod_i  (box_prod_q),
    .quad_lo_o   (quad_lo_d),
    .quad_hi_o   (quad_hi_d),
    .proj_min_o  (proj_min_d),
    .proj_max_o  (proj_max_d)
  );

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      flags2_q   <= flags1_q;
      quad_lo_q  <= quad_lo_d;
      quad_hi_q  <= quad_hi_d;
      proj_min_q <= proj_min_d;
      proj_max_q <= proj_max_d;
    end
  end

  bqo_cmp_stage #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_cmp (
    .flags_i    (flags2_q),
    .quad_lo_i  (quad_lo_q),
    .quad_hi_i  (quad_hi_q),
    .proj_min_i (proj_min_q),
    .proj_max_i (proj_max_q),
    .shadowed_o (shadowed_d)
  );

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      shadowed_q <= shadowed_d;
    end
  end

  assign flag_o.valid           = v3_q;
  assign flag_o.camera_shadowed = shadowed_q;

endmodule

// ===== src/bqo_mul_stage.sv =====
// first stage: edge normals, dot product terms, depth and bounds tests
module bqo_mul_stage #(
  parameter int unsigned COORD_WIDTH = bqo_pkg::COORD_WIDTH_DEF,
  localparam int unsigned CW = (COORD_WIDTH < bqo_pkg::FIELD_W) ? COORD_WIDTH
                                                               : bqo_pkg::FIELD_W,
  localparam int unsigned PW = 2 * CW + 1
) (
  input  logic [bqo_pkg::XY_W-1:0]           corner_a_i,
  input  logic [bqo_pkg::XY_W-1:0]           corner_b_i,
  input  logic [bqo_pkg::XY_W-1:0]           corner_c_i,
  input  logic [bqo_pkg::XY_W-1:0]           corner_d_i,
  input  logic [bqo_pkg::FIELD_W-1:0]        near_top_z_i,
  input  logic signed [bqo_pkg::FIELD_W-1:0] box_low_x_i,
  input  logic signed [bqo_pkg::FIELD_W-1:0] box_low_y_i,
  input  logic signed [bqo_pkg::FIELD_W-1:0] box_low_z_i,
  input  logic signed [bqo_pkg::FIELD_W-1:0] box_high_x_i,
  input  logic signed [bqo_pkg::FIELD_W-1:0] box_high_y_i,
  output bqo_pkg::bqo_flags_t                flags_o,
  output logic signed [PW-1:0]  quad_prod_o [bqo_pkg::NUM_AXES][bqo_pkg::NUM_TERMS],
  output logic signed [PW-1:0]  box_prod_o  [bqo_pkg::NUM_AXES][bqo_pkg::NUM_TERMS]
);
  import bqo_pkg::*;

  logic [XY_W-1:0]      corner [NUM_TERMS];
  logic signed [CW-1:0] cx [NUM_TERMS];
  logic signed [CW-1:0] cy [NUM_TERMS];
  logic signed [CW-1:0] lx, ly, lz, hx, hy, top_z;
  logic signed [CW-1:0] qminx, qmaxx, qminy, qmaxy;
  logic signed [CW:0]   nx [NUM_AXES];
  logic signed [CW:0]   ny [NUM_AXES];
  logic signed [CW-1:0] px [NUM_AXES];
  logic signed [CW-1:0] py [NUM_AXES];
  logic signed [CW-1:0] rx [NUM_AXES];
  logic signed [CW-1:0] ry [NUM_AXES];

  assign corner[0] = corner_a_i;
  assign corner[1] = corner_b_i;
  assign corner[2] = corner_c_i;
  assign corner[3] = corner_d_i;

  assign lx    = box_low_x_i[CW-1:0];
  assign ly    = box_low_y_i[CW-1:0];
  assign lz    = box_low_z_i[CW-1:0];
  assign hx    = box_high_x_i[CW-1:0];
  assign hy    = box_high_y_i[CW-1:0];
  assign top_z = near_top_z_i[CW-1:0];

  always_comb begin
    for (int k = 0; k < NUM_TERMS; k++) begin
      cx[k] = corner[k][CW-1:0];
      cy[k] = corner[k][FIELD_W +: CW];
    end
  end

  // quad xy bounds over all four corners
  always_comb begin
    qminx = cx[0];
    qmaxx = cx[0];
    qminy = cy[0];
    qmaxy = cy[0];
    for (int k = 1; k < NUM_TERMS; k++) begin
      if (cx[k] < qminx) qminx = cx[k];
      if (cx[k] > qmaxx) qmaxx = cx[k];
      if (cy[k] < qminy) qminy = cy[k];
      if (cy[k] > qmaxy) qmaxy = cy[k];
    end
  end

  assign flags_o.depth_sep  = lz > top_z;
  assign flags_o.bounds_sep = (lx > qmaxx) || (hx < qminx) || (ly > qmaxy) || (hy < qminy);

  // edge a to b spans a..c, edge b to c spans b..a
  always_comb begin
    nx[0] = (CW+1)'(cy[0]) - (CW+1)'(cy[1]);
    ny[0] = (CW+1)'(cx[1]) - (CW+1)'(cx[0]);
    nx[1] = (CW+1)'(cy[1]) - (CW+1)'(cy[2]);
    ny[1] = (CW+1)'(cx[2]) - (CW+1)'(cx[1]);
    px[0] = cx[0];
    py[0] = cy[0];
    rx[0] = cx[2];
    ry[0] = cy[2];
    px[1] = cx[1];
    py[1] = cy[1];
    rx[1] = cx[0];
    ry[1] = cy[0];
  end

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      quad_prod_o[a][0] = PW'(nx[a]) * PW'(px[a]);
      quad_prod_o[a][1] = PW'(ny[a]) * PW'(py[a]);
      quad_prod_o[a][2] = PW'(nx[a]) * PW'(rx[a]);
      quad_prod_o[a][3] = PW'(ny[a]) * PW'(ry[a]);
      box_prod_o[a][0]  = PW'(nx[a]) * PW'(lx);
      box_prod_o[a][1]  = PW'(nx[a]) * PW'(hx);
      box_prod_o[a][2]  = PW'(ny[a]) * PW'(ly);
      box_prod_o[a][3]  = PW'(ny[a]) * PW'(hy);
    end
  end

endmodule

// ===== src/bqo_sum_stage.sv =====
// second stage: quad distance range and box projection range per axis
module bqo_sum_stage #(
  parameter int unsigned COORD_WIDTH = bqo_pkg::COORD_WIDTH_DEF,
  localparam int unsigned CW = (COORD_WIDTH < bqo_pkg::FIELD_W) ? COORD_WIDTH
                                                               : bqo_pkg::FIELD_W,
  localparam int unsigned PW = 2 * CW + 1,
  localparam int unsigned DW = PW + 1
) (
  input  logic signed [PW-1:0] quad_prod_i [bqo_pkg::NUM_AXES][bqo_pkg::NUM_TERMS],
  input  logic signed [PW-1:0] box_prod_i  [bqo_pkg::NUM_AXES][bqo_pkg::NUM_TERMS],
  output logic signed [DW-1:0] quad_lo_o   [bqo_pkg::NUM_AXES],
  output logic signed [DW-1:0] quad_hi_o   [bqo_pkg::NUM_AXES],
  output logic signed [DW-1:0] proj_min_o  [bqo_pkg::NUM_AXES],
  output logic signed [DW-1:0] proj_max_o  [bqo_pkg::NUM_AXES]
);
  import bqo_pkg::*;

  logic signed [DW-1:0] dist_p [NUM_AXES];
  logic signed [DW-1:0] dist_r [NUM_AXES];
  logic signed [PW-1:0] x_min [NUM_AXES];
  logic signed [PW-1:0] x_max [NUM_AXES];
  logic signed [PW-1:0] y_min [NUM_AXES];
  logic signed [PW-1:0] y_max [NUM_AXES];

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      dist_p[a] = DW'(quad_prod_i[a][0]) + DW'(quad_prod_i[a][1]);
      dist_r[a] = DW'(quad_prod_i[a][2]) + DW'(quad_prod_i[a][3]);
      if (dist_p[a] > dist_r[a]) begin
        quad_lo_o[a] = dist_r[a];
        quad_hi_o[a] = dist_p[a];
      end else begin
        quad_lo_o[a] = dist_p[a];
        quad_hi_o[a] = dist_r[a];
      end
    end
  end

  // box corners are every x by every y, so the extremes split per term
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      if (box_prod_i[a][0] < box_prod_i[a][1]) begin
        x_min[a] = box_prod_i[a][0];
        x_max[a] = box_prod_i[a][1];
      end else begin
        x_min[a] = box_prod_i[a][1];
        x_max[a] = box_prod_i[a][0];
      end
      if (box_prod_i[a][2] < box_prod_i[a][3]) begin
        y_min[a] = box_prod_i[a][2];
        y_max[a] = box_prod_i[a][3];
      end else begin
        y_min[a] = box_prod_i[a][3];
        y_max[a] = box_prod_i[a][2];
      end
      proj_min_o[a] = DW'(x_min[a]) + DW'(y_min[a]);
      proj_max_o[a] = DW'(x_max[a]) + DW'(y_max[a]);
    end
  end

endmodule

// ===== src/bqo_cmp_stage.sv =====
// last stage: range overlap per axis and the combined overlap flag
module bqo_cmp_stage #(
  parameter int unsigned COORD_WIDTH = bqo_pkg::COORD_WIDTH_DEF,
  localparam int unsigned CW = (COORD_WIDTH < bqo_pkg::FIELD_W) ? COORD_WIDTH
                                                               : bqo_pkg::FIELD_W,
  localparam int unsigned DW = 2 * CW + 2
) (
  input  bqo_pkg::bqo_flags_t  flags_i,
  input  logic signed [DW-1:0] quad_lo_i  [bqo_pkg::NUM_AXES],
  input  logic signed [DW-1:0] quad_hi_i  [bqo_pkg::NUM_AXES],
  input  logic signed [DW-1:0] proj_min_i [bqo_pkg::NUM_AXES],
  input  logic signed [DW-1:0] proj_max_i [bqo_pkg::NUM_AXES],
  output logic                 shadowed_o
);
  import bqo_pkg::*;

  logic [NUM_AXES-1:0] axis_sep;

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      axis_sep[a] = (quad_lo_i[a] > proj_max_i[a]) || (proj_min_i[a] > quad_hi_i[a]);
    end
  end

  assign shadowed_o = !(flags_i.depth_sep || flags_i.bounds_sep || (|axis_sep));

endmodule

// ===== src/bqo_chk.sv =====
// port-level checker for the overlap test, bound to the top level
`include "box_quad_overlap_sat_test_defines.svh"

module bqo_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic box_ready_i,
  input logic flag_valid_i,
  input logic flag_ready_i,
  input logic flag_shadowed_i,
  input logic cfg_ready_i
);

  `BQO_ASSERT_NOW(cfg_always_ready, 1'b1, cfg_ready_i, "register write not taken")

  `BQO_ASSERT_NOW(ready_when_drained, !flag_valid_i, box_ready_i, "box refused with output empty")

  `BQO_ASSERT_NEXT(result_held, flag_valid_i && !flag_ready_i, flag_valid_i && $stable(flag_shadowed_i), "stalled result changed")

endmodule

bind box_quad_overlap_sat_test bqo_chk u_bqo_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .box_ready_i     (box_i.ready),
  .flag_valid_i    (flag_o.valid),
  .flag_ready_i    (flag_o.ready),
  .flag_shadowed_i (flag_o.camera_shadowed),
  .cfg_ready_i     (cfg_i.ready)
);
